>>> rtl/pfl_pkg.sv
// shared constants, codes and types for the page free list allocator
`default_nettype none
package pfl_pkg;

  localparam int PAGE_BYTES   = 1024;
  localparam int MAX_PAGES    = 256;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int IDX_W        = $clog2(MAX_PAGES);
  localparam int CNT_W        = $clog2(MAX_PAGES + 1);
  localparam int ADDR_W       = 32;
  localparam int FREE_COUNT_W = 9;
  localparam int PG_W         = ADDR_W - PAGE_SHIFT;
  localparam int CFG_INDEX_W  = 8;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_START = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_END   = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BADADDR = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_CHECK,
    S_FILL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic check;
    logic fill;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_init;
    logic fill_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/pfl_ctrl.sv
// controller state machine sequencing calc, check, fill and finish steps
`default_nettype none
module pfl_ctrl
  import pfl_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CALC;
      end
      S_CALC:  state_next = S_CHECK;
      S_CHECK: state_next = stat.is_init ? S_FILL : S_FINISH;
      S_FILL: begin
        if (stat.fill_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_CALC:   cmd.calc = 1'b1;
      S_CHECK:  cmd.check = 1'b1;
      S_FILL:   cmd.fill = !stat.fill_done;
      S_FINISH: cmd.finish = stat.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/pfl_dp.sv
// datapath: config registers, free stack memory, address checks, result register
`default_nettype none
module pfl_dp
  import pfl_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  input  wire cmd_t                    cmd,
  output stat_t                        stat,
  input  wire  [1:0]                   in_op,
  input  wire  [ADDR_W-1:0]            in_addr,
  input  wire                          cfg_we,
  input  wire  [CFG_INDEX_W-1:0]       cfg_index,
  input  wire  [ADDR_W-1:0]            cfg_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_status,
  output logic [ADDR_W-1:0]            out_addr,
  output logic [FREE_COUNT_W-1:0]      out_count
);

  logic [ADDR_W-1:0] heap_start;
  logic [ADDR_W-1:0] heap_end;

  logic [IDX_W-1:0] free_stack [MAX_PAGES];
  logic [IDX_W-1:0] rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;

  logic [CNT_W-1:0] stack_count;
  op_t              op;
  logic [ADDR_W-1:0] page_addr;

  // calc stage
  logic [ADDR_W:0] diff_a;
  logic [ADDR_W:0] off_a;
  logic [ADDR_W:0] endp_a;

  // check stage
  logic [CNT_W-1:0]  pages;
  logic              bad;
  logic              full;
  logic              empty;
  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] alloc_addr;
  logic [CNT_W-1:0]  fill_i;

  logic [PG_W-1:0]   pg_raw;
  logic [CNT_W-1:0]  pages_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start <= '0;
      heap_end   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_HEAP_START) heap_start <= cfg_data;
      if (cfg_index == REG_HEAP_END)   heap_end   <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op        <= op_t'(in_op);
      page_addr <= in_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      diff_a <= {1'b0, heap_end} - {1'b0, heap_start};
      off_a  <= {1'b0, page_addr} - {1'b0, heap_start};
      endp_a <= {1'b0, page_addr} + (ADDR_W+1)'(PAGE_BYTES);
    end
  end

  // page count of the heap, zero if the end lies below the start, capped at the stack depth
  always_comb begin
    pg_raw = diff_a[ADDR_W-1:PAGE_SHIFT];
    if (diff_a[ADDR_W]) begin
      pages_calc = '0;
    end else if (pg_raw > PG_W'(MAX_PAGES)) begin
      pages_calc = CNT_W'(MAX_PAGES);
    end else begin
      pages_calc = CNT_W'(pg_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      pages      <= pages_calc;
      bad        <= off_a[ADDR_W]
                  || (off_a[PAGE_SHIFT-1:0] != '0)
                  || (endp_a > {1'b0, heap_end})
                  || (off_a[ADDR_W-1:PAGE_SHIFT] >= PG_W'(MAX_PAGES));
      full       <= (stack_count >= CNT_W'(MAX_PAGES));
      empty      <= (stack_count == '0);
      idx        <= off_a[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT];
      alloc_addr <= heap_start + (ADDR_W'(rd_data) << PAGE_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      fill_i <= '0;
    end else if (cmd.fill) begin
      fill_i <= fill_i + CNT_W'(1);
    end
  end

  // single write port shared by the init sweep and free pushes
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = stack_count[IDX_W-1:0];
    mem_wdata = idx;
    if (cmd.fill) begin
      mem_we    = 1'b1;
      mem_waddr = fill_i[IDX_W-1:0];
      mem_wdata = IDX_W'(pages - fill_i - CNT_W'(1));
    end else if (cmd.finish && op == OP_FREE && !bad && !full) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) free_stack[mem_waddr] <= mem_wdata;
  end

  // top of stack read, issued during calc
  always_ff @(posedge clk) begin
    if (cmd.calc) rd_data <= free_stack[IDX_W'(stack_count - CNT_W'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
    end else if (cmd.finish) begin
      case (op)
        OP_INIT:  stack_count <= pages;
        OP_ALLOC: if (!empty) stack_count <= stack_count - CNT_W'(1);
        OP_FREE:  if (!bad && !full) stack_count <= stack_count + CNT_W'(1);
        OP_NOP:   stack_count <= stack_count;
        default:  stack_count <= stack_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= ST_OK;
      out_addr   <= '0;
      out_count  <= FREE_COUNT_W'(stack_count);
      case (op)
        OP_INIT: out_count <= FREE_COUNT_W'(pages);
        OP_ALLOC: begin
          if (empty) begin
            out_status <= ST_EMPTY;
          end else begin
            out_addr  <= alloc_addr;
            out_count <= FREE_COUNT_W'(stack_count - CNT_W'(1));
          end
        end
        OP_FREE: begin
          if (bad) begin
            out_status <= ST_BADADDR;
          end else if (full) begin
            out_status <= ST_FULL;
          end else begin
            out_count <= FREE_COUNT_W'(stack_count + CNT_W'(1));
          end
        end
        OP_NOP:  out_status <= ST_OK;
        default: out_status <= ST_OK;
      endcase
    end
  end

  assign stat.is_init   = (op == OP_INIT);
  assign stat.fill_done = (fill_i == pages);
  assign stat.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

>>> rtl/page_free_list_allocator_core.sv
// top level of the page free list allocator
//
//  channel  direction  handshake         payload
//  s_*      in         s_tvalid/tready   tuser op, tdata page_addr
//  m_*      out        m_tvalid/tready   tuser status, tdata result_addr, free_count
//  cfg_*    in         cfg_valid/ready   cfg_index register, cfg_data value
//
//  alloc, free and no-op pass through accept, offset/address sums with the
//  stack read, range checks and page address, result load; the result load
//  waits while an earlier result is held. init sweeps the single-port stack
//  memory between checks and result load, one entry a cycle, then sees it done.
//  one item is in work at a time; a new one is taken while a result waits on
//  m_tready. reset clears the count, heap registers and output valid; stack
//  entries stay undefined until written. cfg is always ready.
`default_nettype none
module page_free_list_allocator_core
  import pfl_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  wire  [IN_DATA_W-1:0]   s_tdata,   // [31:0] page_addr
  input  wire  [1:0]             s_tuser,   // [1:0] op
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // [31:0] result_addr, [40:32] free_count
  output logic [1:0]             m_tuser,   // [1:0] status
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [ADDR_W-1:0]      cfg_data
);

  cmd_t                    cmd;
  stat_t                   stat;
  logic [ADDR_W-1:0]       res_addr;
  logic [FREE_COUNT_W-1:0] res_count;

  assign cfg_ready = 1'b1;

  pfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_tuser),
    .in_addr    (s_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_addr   (res_addr),
    .out_count  (res_count)
  );

  assign m_tdata = {(OUT_DATA_W - ADDR_W - FREE_COUNT_W)'(0), res_count, res_addr};

endmodule
`default_nettype wire
